@@ rtl/rtcp_report_parser_defines.svh @@
// Assertion macros for the RTCP report parser.
// Used by rtcp_report_parser.sv; expects clk and rst_n in scope.
`ifndef RTCP_REPORT_PARSER_DEFINES_SVH
`define RTCP_REPORT_PARSER_DEFINES_SVH

// Check that cond implies check in the same cycle.
`define RP_ASSERT_NOW(lbl, cond, check, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Check that cond implies check in the next cycle.
`define RP_ASSERT_NEXT(lbl, cond, check, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

@@ rtl/rtcp_rp_pkg.sv @@
// Shared types and constants of the RTCP report parser.
// No dependencies; the parser and the result queue import it.
package rtcp_rp_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2047;
    localparam int QUEUE_DEPTH          = 4;
    localparam int REC_BYTES            = 24;

    // Packet kinds
    localparam logic [1:0] KIND_RR  = 2'd0;
    localparam logic [1:0] KIND_SR  = 2'd1;
    localparam logic [1:0] KIND_PLI = 2'd2;

    // Record kinds
    localparam logic [1:0] REC_HEADER = 2'd0;
    localparam logic [1:0] REC_INFO   = 2'd1;
    localparam logic [1:0] REC_REPORT = 2'd2;
    localparam logic [1:0] REC_END    = 2'd3;

    // End status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Byte counts of the records and length rules
    localparam int HEAD_BYTES    = 4;
    localparam int RR_INFO_BYTES = 4;
    localparam int SR_INFO_BYTES = 24;
    localparam int PLI_INFO_BYTES = 8;
    localparam int RR_MIN_BYTES  = 8;
    localparam int SR_MIN_BYTES  = 28;
    localparam int PLI_BYTES     = 12;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [1:0]  status;
        logic        rtcp_like;
        logic [31:0] ssrc;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [31:0] word_e;
        logic [7:0]  frac_lost;
        logic [23:0] cum_lost;
        logic        last_result;
    } rec_t;

    // Up to two records pushed per accepted byte
    typedef struct packed {
        logic [1:0] count;
        rec_t       first;
        rec_t       second;
    } push_t;

endpackage

@@ rtl/rtcp_rp_byte_if.sv @@
// Input channel of the RTCP report parser: one packet byte per word.
// No dependencies.
interface rtcp_rp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic [1:0] packet_kind;

    modport source (output valid, output data_byte, output end_of_packet,
                    output packet_kind, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet,
                    input packet_kind, output ready);
endinterface

@@ rtl/rtcp_rp_rec_if.sv @@
// Output channel of the RTCP report parser: one decoded record per word.
// No dependencies.
interface rtcp_rp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [1:0]  status;
    logic        rtcp_like;
    logic [31:0] ssrc;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic [31:0] word_e;
    logic [7:0]  frac_lost;
    logic [23:0] cum_lost;
    logic        last_result;

    modport source (output valid, output record_kind, output status, output rtcp_like,
                    output ssrc, output word_a, output word_b, output word_c,
                    output word_d, output word_e, output frac_lost,
                    output cum_lost, output last_result, input ready);
    modport sink   (input valid, input record_kind, input status, input rtcp_like,
                    input ssrc, input word_a, input word_b, input word_c,
                    input word_d, input word_e, input frac_lost,
                    input cum_lost, input last_result, output ready);
endinterface

@@ rtl/rtcp_report_parser.sv @@
// RTCP report parser top level: byte-wise decoder of RR, SR and PLI packets.
// Depends on rtcp_rp_pkg, rtcp_rp_byte_if, rtcp_rp_rec_if, rtcp_rp_queue and
// rtcp_report_parser_defines.svh.
//
// Usage:
//   byte_in carries one packet byte per word in wire order; end_of_packet
//   marks the final byte, packet_kind (0 RR, 1 SR, 2 PLI) is sampled on the
//   first byte of each packet only.
//   rec_out carries decoded records: the common header, then sender or
//   feedback info, then report blocks, each as soon as its last byte lands;
//   the final byte of a packet also yields an end record with the status.
//   last_result flags the last record caused by a byte.
// Output: a record enters the result queue with the byte that completes it
//   and is offered on rec_out from there. Throughput: one byte per cycle; a
//   byte never causes more than two records, and the four-entry result queue
//   lets bytes in while it has room for two.
// Stall: when rec_out is held off the queue fills and ready on byte_in
//   drops once fewer than two entries are free; nothing is lost.
// Reset: rst_n clears the parser to wait for the first byte of a packet and
//   empties the result queue.
// The byte offset counter saturates at MAX_PACKET_BYTES.
`include "rtcp_report_parser_defines.svh"

module rtcp_report_parser #(
    parameter int MAX_PACKET_BYTES = rtcp_rp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rtcp_rp_byte_if.sink  byte_in,
    rtcp_rp_rec_if.source rec_out
);
    import rtcp_rp_pkg::*;

    localparam int OffW  = $clog2(MAX_PACKET_BYTES + 1);
    localparam int FillW = $clog2(REC_BYTES + 1);

    typedef enum logic [1:0] {PH_HEAD, PH_INFO, PH_REPORTS, PH_IDLE} phase_t;

    // Parser state
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;
    logic [4:0]       left_reg;
    logic [4:0]       left_next;
    logic [OffW-1:0]  off_reg;
    logic [OffW-1:0]  off_next;
    logic [1:0]       kind_reg;
    logic [1:0]       kind_next;
    logic             in_packet_reg;
    logic             in_packet_next;
    logic [7:0]       rb_reg [REC_BYTES];

    // Per-byte working values
    logic             accept;
    logic             start;
    logic             eop;
    logic [7:0]       b;
    phase_t           phase_eff;
    logic [FillW-1:0] fill_eff;
    logic [FillW-1:0] fill_inc;
    logic [FillW-1:0] info_target;
    logic [4:0]       left_eff;
    logic [OffW-1:0]  off_eff;
    logic [OffW-1:0]  off_inc;
    logic [7:0]       eb [REC_BYTES];
    logic             have_data;
    logic             bad_len;
    rec_t             data_rec;
    rec_t             end_rec;
    push_t            push;
    logic             q_space;
    logic             q_valid;
    rec_t             q_head;

    assign accept = byte_in.valid && byte_in.ready;
    assign start  = !in_packet_reg;
    assign eop    = byte_in.end_of_packet;
    assign b      = byte_in.data_byte;

    always_comb
    begin
        kind_next = start ? byte_in.packet_kind : kind_reg;
        phase_eff = start ? PH_HEAD : phase_reg;
        fill_eff  = start ? '0 : fill_reg;
        left_eff  = start ? '0 : left_reg;
        off_eff   = start ? '0 : off_reg;
        off_inc   = (off_eff < OffW'(MAX_PACKET_BYTES)) ? off_eff + 1'b1 : off_eff;
        fill_inc  = fill_eff + 1'b1;

        // Current record bytes with the incoming byte merged in
        for (int k = 0; k < REC_BYTES; k++)
        begin
            eb[k] = (fill_eff == FillW'(k)) ? b : rb_reg[k];
        end

        case (kind_next)
            KIND_RR: info_target = FillW'(RR_INFO_BYTES);
            KIND_SR: info_target = FillW'(SR_INFO_BYTES);
            default: info_target = FillW'(PLI_INFO_BYTES);
        endcase

        phase_next = phase_eff;
        fill_next  = fill_eff;
        left_next  = left_eff;
        have_data  = 1'b0;
        data_rec   = '0;

        if (phase_eff != PH_IDLE)
        begin
            fill_next = fill_inc;
            case (phase_eff)
                PH_HEAD:
                begin
                    if (fill_inc == FillW'(HEAD_BYTES))
                    begin
                        have_data            = 1'b1;
                        data_rec.record_kind = REC_HEADER;
                        data_rec.rtcp_like   = (eb[0] inside {[8'd128:8'd191]}) &&
                                               (eb[1] inside {[8'd192:8'd223]});
                        data_rec.word_a      = {30'd0, eb[0][7:6]};
                        data_rec.word_b      = {31'd0, eb[0][5]};
                        data_rec.word_c      = {27'd0, eb[0][4:0]};
                        data_rec.word_d      = {24'd0, eb[1]};
                        data_rec.word_e      = {16'd0, eb[2], eb[3]};
                        left_next            = eb[0][4:0];
                        fill_next            = '0;
                        phase_next           = (kind_next <= KIND_PLI) ? PH_INFO : PH_IDLE;
                    end
                end
                PH_INFO:
                begin
                    if (fill_inc == info_target)
                    begin
                        have_data            = 1'b1;
                        data_rec.record_kind = REC_INFO;
                        data_rec.ssrc        = {eb[0], eb[1], eb[2], eb[3]};
                        if (kind_next == KIND_SR)
                        begin
                            data_rec.word_a = {eb[4], eb[5], eb[6], eb[7]};
                            data_rec.word_b = {eb[8], eb[9], eb[10], eb[11]};
                            data_rec.word_c = {eb[12], eb[13], eb[14], eb[15]};
                            data_rec.word_d = {eb[16], eb[17], eb[18], eb[19]};
                            data_rec.word_e = {eb[20], eb[21], eb[22], eb[23]};
                        end
                        else if (kind_next == KIND_PLI)
                        begin
                            data_rec.word_a = {eb[4], eb[5], eb[6], eb[7]};
                        end
                        fill_next  = '0;
                        phase_next = (kind_next != KIND_PLI && left_eff != '0) ?
                                     PH_REPORTS : PH_IDLE;
                    end
                end
                default:
                begin
                    if (fill_inc == FillW'(REC_BYTES))
                    begin
                        have_data            = 1'b1;
                        data_rec.record_kind = REC_REPORT;
                        data_rec.ssrc        = {eb[0], eb[1], eb[2], eb[3]};
                        data_rec.frac_lost   = eb[4];
                        data_rec.cum_lost    = {eb[5], eb[6], eb[7]};
                        data_rec.word_a      = {eb[8], eb[9], eb[10], eb[11]};
                        data_rec.word_b      = {eb[12], eb[13], eb[14], eb[15]};
                        data_rec.word_c      = {eb[16], eb[17], eb[18], eb[19]};
                        data_rec.word_d      = {eb[20], eb[21], eb[22], eb[23]};
                        fill_next            = '0;
                        left_next            = left_eff - 1'b1;
                        if (left_next == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            endcase
        end

        // Length check on the final byte
        case (kind_next)
            KIND_RR:  bad_len = (off_inc < OffW'(RR_MIN_BYTES));
            KIND_SR:  bad_len = (off_inc < OffW'(SR_MIN_BYTES));
            KIND_PLI: bad_len = (off_inc != OffW'(PLI_BYTES));
            default:  bad_len = 1'b1;
        endcase

        end_rec             = '0;
        end_rec.record_kind = REC_END;
        end_rec.last_result = 1'b1;
        if (bad_len)
        begin
            end_rec.status = ST_SHORT;
        end
        else if (phase_next == PH_REPORTS && left_next != '0 && fill_next != '0)
        begin
            end_rec.status = ST_TRUNC;
        end
        else
        begin
            end_rec.status = ST_OK;
        end

        data_rec.last_result = !eop;
        off_next             = off_inc;
        in_packet_next       = 1'b1;

        // End of packet: drop back to waiting for a new packet
        if (eop)
        begin
            phase_next     = PH_HEAD;
            fill_next      = '0;
            left_next      = '0;
            off_next       = '0;
            in_packet_next = 1'b0;
        end

        // Pack the records into the queue, data record first
        push = '0;
        if (accept)
        begin
            push.count  = {1'b0, have_data} + {1'b0, eop};
            push.first  = have_data ? data_rec : end_rec;
            push.second = end_rec;
        end
    end

    // Control state advances on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            fill_reg      <= '0;
            left_reg      <= '0;
            off_reg       <= '0;
            kind_reg      <= KIND_RR;
            in_packet_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            off_reg       <= off_next;
            kind_reg      <= kind_next;
            in_packet_reg <= in_packet_next;
        end
    end

    // Record byte buffer: hold bytes of the record being assembled
    always_ff @(posedge clk)
    begin
        if (accept && phase_eff != PH_IDLE)
        begin
            rb_reg[fill_eff] <= b;
        end
    end

    rtcp_rp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (q_space),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (rec_out.ready)
    );

    assign byte_in.ready       = q_space;
    assign rec_out.valid       = q_valid;
    assign rec_out.record_kind = q_head.record_kind;
    assign rec_out.status      = q_head.status;
    assign rec_out.rtcp_like   = q_head.rtcp_like;
    assign rec_out.ssrc        = q_head.ssrc;
    assign rec_out.word_a      = q_head.word_a;
    assign rec_out.word_b      = q_head.word_b;
    assign rec_out.word_c      = q_head.word_c;
    assign rec_out.word_d      = q_head.word_d;
    assign rec_out.word_e      = q_head.word_e;
    assign rec_out.frac_lost   = q_head.frac_lost;
    assign rec_out.cum_lost    = q_head.cum_lost;
    assign rec_out.last_result = q_head.last_result;

    `RP_ASSERT_NOW(a_idle_fill_clear, phase_reg == PH_IDLE, fill_reg == '0,
        "fill count not cleared in idle phase")
    `RP_ASSERT_NOW(a_fill_in_range, 1'b1, fill_reg < FillW'(REC_BYTES),
        "fill count beyond record buffer")
    `RP_ASSERT_NEXT(a_eop_closes, accept && eop, !in_packet_reg && off_reg == '0,
        "end of packet did not close the packet")
    `RP_ASSERT_NEXT(a_mid_packet, accept && !eop, in_packet_reg,
        "packet closed without end of packet")

endmodule

@@ rtl/rtcp_rp_queue.sv @@
// Result queue of the RTCP report parser: takes up to two records a cycle,
// hands out one. Depends on rtcp_rp_pkg.
module rtcp_rp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  rtcp_rp_pkg::push_t  push,
    output logic                space,
    output logic                head_valid,
    output rtcp_rp_pkg::rec_t   head,
    input  logic                pop
);
    import rtcp_rp_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    rec_t            entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wptr_reg;
    logic [PtrW-1:0] wptr_next;
    logic [PtrW-1:0] wptr_plus;
    logic [PtrW-1:0] rptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rptr_reg];
    // Room for a full pair of records
    assign space      = (count_reg <= CntW'(QUEUE_DEPTH - 2));
    assign wptr_plus  = wptr_reg + 1'b1;
    assign wptr_next  = wptr_reg + PtrW'(push.count);
    assign count_next = count_reg + CntW'(push.count) - CntW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wptr_plus] <= push.second;
        end
    end

endmodule

@@ verif/rtcp_report_parser_tb.sv @@
// Self-checking testbench of the RTCP report parser: packets go in a byte per word,
// decoded records are checked against an in-bench decoder of RR, SR and PLI packets.
// Depends on rtcp_rp_pkg, rtcp_rp_byte_if, rtcp_rp_rec_if and rtcp_report_parser.
module rtcp_report_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcp_rp_pkg::*;

    localparam int MAX_BYTES   = MAX_PACKET_BYTES_DEF;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    // Generous cap on the simulated run time.
    localparam int RUN_LIMIT_NS = 4_000_000;

    // Packet kind that the parser has no decoder for.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Payload types of well-formed headers.
    localparam logic [7:0] PT_SR   = 8'd200;
    localparam logic [7:0] PT_RR   = 8'd201;
    localparam logic [7:0] PT_PSFB = 8'd206;

    // Header byte 0 and byte 1 bounds that make a header look like RTCP.
    localparam int V2_LOW   = 128;
    localparam int V2_HIGH  = 191;
    localparam int PT_LOW   = 192;
    localparam int PT_HIGH  = 223;

    // Where the decoder stands within a packet.
    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_INFO,
        SCAN_REPORTS,
        SCAN_DONE
    } scan_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    rtcp_rp_byte_if byte_ch ();
    rtcp_rp_rec_if  rec_ch ();

    rtcp_report_parser DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .rec_out (rec_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder state mirrored from the block: it follows every accepted
    // byte and turns it into the records the block must emit.
    // ------------------------------------------------------------------
    int          pkt_offset;
    logic [7:0]  rec_buf [REC_BYTES];
    logic [4:0]  blocks_left;
    logic [1:0]  cur_kind;
    logic        mid_packet;
    scan_phase_t scan_phase;
    int          buf_fill;

    rec_t pending_records[$];
    int   error_count;

    // Knobs of the traffic shape, set by the tests.
    int   send_idle_pct;
    int   stall_pct;
    logic holding;

    // Packet under construction and a running count of bytes sent.
    logic [7:0] wire_bytes[$];
    int         bytes_sent;

    // Big-endian 32-bit word out of the record buffer.
    function automatic logic [31:0] word_at(int idx);
        return {rec_buf[idx], rec_buf[idx + 1], rec_buf[idx + 2], rec_buf[idx + 3]};
    endfunction

    // Advance the decoder by one byte and queue the records it completes.
    function automatic void decode_byte(logic [7:0] value, logic last, logic [1:0] kind);
        rec_t made [2];
        int   produced;
        int   need;
        logic bad;

        produced = 0;
        if (!mid_packet)
        begin
            // Latch the kind on the first byte; reset the per-packet state.
            cur_kind    = kind;
            mid_packet  = 1'b1;
            scan_phase  = SCAN_HEADER;
            buf_fill    = 0;
            pkt_offset  = 0;
            blocks_left = '0;
        end
        if (pkt_offset < MAX_BYTES)
            pkt_offset++;

        if (scan_phase != SCAN_DONE)
        begin
            rec_buf[buf_fill] = value;
            buf_fill++;
            case (scan_phase)
                SCAN_HEADER:
                    if (buf_fill == HEAD_BYTES)
                    begin
                        made[produced] = '0;
                        made[produced].record_kind = REC_HEADER;
                        made[produced].rtcp_like =
                            (rec_buf[0] >= V2_LOW) && (rec_buf[0] <= V2_HIGH) &&
                            (rec_buf[1] >= PT_LOW) && (rec_buf[1] <= PT_HIGH);
                        made[produced].word_a = 32'(rec_buf[0][7:6]);
                        made[produced].word_b = 32'(rec_buf[0][5]);
                        made[produced].word_c = 32'(rec_buf[0][4:0]);
                        made[produced].word_d = 32'(rec_buf[1]);
                        made[produced].word_e = {16'h0, rec_buf[2], rec_buf[3]};
                        produced++;
                        blocks_left = rec_buf[0][4:0];
                        buf_fill    = 0;
                        // No decoder for the unused kind: skip the rest.
                        scan_phase  = (cur_kind == KIND_UNUSED) ? SCAN_DONE : SCAN_INFO;
                    end
                SCAN_INFO:
                begin
                    need = (cur_kind == KIND_RR) ? RR_INFO_BYTES :
                           (cur_kind == KIND_SR) ? SR_INFO_BYTES : PLI_INFO_BYTES;
                    if (buf_fill == need)
                    begin
                        made[produced] = '0;
                        made[produced].record_kind = REC_INFO;
                        made[produced].ssrc = word_at(0);
                        if (cur_kind == KIND_SR)
                        begin
                            made[produced].word_a = word_at(4);
                            made[produced].word_b = word_at(8);
                            made[produced].word_c = word_at(12);
                            made[produced].word_d = word_at(16);
                            made[produced].word_e = word_at(20);
                        end
                        else if (cur_kind == KIND_PLI)
                            made[produced].word_a = word_at(4);
                        produced++;
                        buf_fill   = 0;
                        scan_phase = (cur_kind != KIND_PLI && blocks_left != 0) ?
                                     SCAN_REPORTS : SCAN_DONE;
                    end
                end
                default:
                    if (buf_fill == REC_BYTES)
                    begin
                        made[produced] = '0;
                        made[produced].record_kind = REC_REPORT;
                        made[produced].ssrc        = word_at(0);
                        made[produced].frac_lost   = rec_buf[4];
                        made[produced].cum_lost    = {rec_buf[5], rec_buf[6], rec_buf[7]};
                        made[produced].word_a      = word_at(8);
                        made[produced].word_b      = word_at(12);
                        made[produced].word_c      = word_at(16);
                        made[produced].word_d      = word_at(20);
                        produced++;
                        buf_fill    = 0;
                        blocks_left = blocks_left - 5'd1;
                        if (blocks_left == 0)
                            scan_phase = SCAN_DONE;
                    end
            endcase
        end

        if (last)
        begin
            case (cur_kind)
                KIND_RR:  bad = pkt_offset < RR_MIN_BYTES;
                KIND_SR:  bad = pkt_offset < SR_MIN_BYTES;
                KIND_PLI: bad = pkt_offset != PLI_BYTES;
                default:  bad = 1'b1;
            endcase
            made[produced] = '0;
            made[produced].record_kind = REC_END;
            if (bad)
                made[produced].status = ST_SHORT;
            else if (scan_phase == SCAN_REPORTS && blocks_left != 0 && buf_fill != 0)
                made[produced].status = ST_TRUNC;
            else
                made[produced].status = ST_OK;
            produced++;
            mid_packet  = 1'b0;
            scan_phase  = SCAN_HEADER;
            buf_fill    = 0;
            blocks_left = '0;
            pkt_offset  = 0;
        end

        // Flag the final record of this byte.
        for (int i = 0; i < produced; i++)
        begin
            made[i].last_result = (i == produced - 1);
            pending_records.insert(pending_records.size(), made[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Record checker: compare every accepted record with the oldest one
    // still pending, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n && rec_ch.valid && rec_ch.ready)
        begin
            if (pending_records.size() == 0)
            begin
                $error("record_kind: expected none, got %0h", rec_ch.record_kind);
                error_count++;
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("record_kind", 32'(want.record_kind), 32'(rec_ch.record_kind));
                check_field("status", 32'(want.status), 32'(rec_ch.status));
                check_field("rtcp_like", 32'(want.rtcp_like), 32'(rec_ch.rtcp_like));
                check_field("ssrc", want.ssrc, rec_ch.ssrc);
                check_field("word_a", want.word_a, rec_ch.word_a);
                check_field("word_b", want.word_b, rec_ch.word_b);
                check_field("word_c", want.word_c, rec_ch.word_c);
                check_field("word_d", want.word_d, rec_ch.word_d);
                check_field("word_e", want.word_e, rec_ch.word_e);
                check_field("frac_lost", 32'(want.frac_lost), 32'(rec_ch.frac_lost));
                check_field("cum_lost", 32'(want.cum_lost), 32'(rec_ch.cum_lost));
                check_field("last_result", 32'(want.last_result), 32'(rec_ch.last_result));
            end
        end
    end

    // ------------------------------------------------------------------
    // Record sink: stall at random per stall_pct; drop ready for the whole
    // hold-off window while holding is set.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || holding)
            rec_ch.ready <= 1'b0;
        else
            rec_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------

    // Offer one byte, hold it until accepted, then feed it to the decoder.
    task automatic send_byte(input logic [7:0] value, input logic last,
                             input logic [1:0] kind);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= value;
        byte_ch.end_of_packet <= last;
        byte_ch.packet_kind   <= kind;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        decode_byte(value, last, kind);
    endtask

    // Send wire_bytes as one packet; later bytes carry a random kind, which
    // the block must ignore.
    task automatic send_packet(input logic [1:0] kind);
        logic [1:0] byte_kind;
        for (int i = 0; i < wire_bytes.size(); i++)
        begin
            byte_kind = (i == 0) ? kind : 2'($urandom_range(3, 0));
            send_byte(wire_bytes[i], i == wire_bytes.size() - 1, byte_kind);
            bytes_sent++;
        end
    endtask

    // Append one byte to the packet under construction.
    function automatic void append_byte(input logic [7:0] value);
        wire_bytes.insert(wire_bytes.size(), value);
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            append_byte(8'($urandom_range(255, 0)));
    endtask

    // Build and send one packet: mostly well formed with random content,
    // the rest cut short, cut inside a block, padded, or plain noise.
    task automatic send_random_packet();
        logic [1:0]  kind;
        logic [7:0]  head0;
        logic [7:0]  head1;
        logic [15:0] len_words;
        int          count;
        int          blocks;
        int          body;
        int          shape;
        int          cut;

        wire_bytes.delete();
        case ($urandom_range(9, 0))
            0, 1, 2: kind = KIND_RR;
            3, 4, 5: kind = KIND_SR;
            6, 7, 8: kind = KIND_PLI;
            default: kind = KIND_UNUSED;
        endcase
        shape = $urandom_range(99, 0);

        if (shape >= 95)
        begin
            push_random($urandom_range(40, 1));
            send_packet(2'($urandom_range(3, 0)));
            return;
        end

        count = ($urandom_range(14, 0) == 0) ? $urandom_range(31, 4) : $urandom_range(3, 0);
        head0 = 8'h80 | 8'($urandom_range(1, 0) << 5) | 8'(count);
        if ($urandom_range(7, 0) == 0)
        begin
            head0 = 8'($urandom_range(255, 0));
            count = int'(head0[4:0]);
        end

        case (kind)
            KIND_RR:  begin body = RR_INFO_BYTES;  head1 = PT_RR;   end
            KIND_SR:  begin body = SR_INFO_BYTES;  head1 = PT_SR;   end
            KIND_PLI: begin body = PLI_INFO_BYTES; head1 = PT_PSFB; end
            default:  begin body = $urandom_range(20, 0); head1 = PT_RR; end
        endcase
        if ($urandom_range(7, 0) == 0)
            head1 = 8'($urandom_range(255, 0));

        // Cap the blocks actually present so that large counts stay cheap.
        if (kind == KIND_PLI || kind == KIND_UNUSED)
            blocks = 0;
        else if (count <= 3)
            blocks = count;
        else
        begin
            blocks = $urandom_range(count, 0);
            if (blocks > 6)
                blocks = 6;
        end

        len_words = 16'((HEAD_BYTES + body + REC_BYTES * blocks) / 4 - 1);
        if ($urandom_range(9, 0) == 0)
            len_words = 16'($urandom_range(65535, 0));

        append_byte(head0);
        append_byte(head1);
        append_byte(len_words[15:8]);
        append_byte(len_words[7:0]);
        push_random(body + REC_BYTES * blocks);

        if (shape >= 65 && shape < 77)
        begin
            // Cut short anywhere.
            cut = $urandom_range(wire_bytes.size() - 1, 1);
            while (wire_bytes.size() > cut)
                void'(wire_bytes.pop_back());
        end
        else if (shape >= 77 && shape < 87)
        begin
            // Drop the tail of the last block, or pad into a block not sent.
            if (blocks > 0)
            begin
                cut = $urandom_range(REC_BYTES - 1, 1);
                repeat (cut)
                    void'(wire_bytes.pop_back());
            end
            else
                push_random($urandom_range(REC_BYTES - 1, 1));
        end
        else if (shape >= 87)
            push_random($urandom_range(10, 1));

        send_packet(kind);
    endtask

    task automatic send_random_stream(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_packet();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and the corner cases, one short packet each.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;

        // RR of all ones: count 31 but no blocks follow, which is still ok.
        wire_bytes.delete();
        repeat (RR_MIN_BYTES)
            append_byte(8'hFF);
        send_packet(KIND_RR);

        // PLI of exactly twelve bytes, zero sender ssrc.
        wire_bytes = '{8'h81, PT_PSFB, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
        push_random(4);
        send_packet(KIND_PLI);

        // Unused kind: header at the upper type bound, then an error status.
        wire_bytes = '{8'h80, 8'd223, 8'h00, 8'h00};
        send_packet(KIND_UNUSED);

        // Single byte packet: too short for anything but the end record.
        wire_bytes = '{8'h7F};
        send_packet(KIND_SR);
    endtask

    task automatic test_streaming();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_random_stream(450);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 86;
        stall_pct     = 0;
        send_random_stream(450);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct     = 86;
        send_random_stream(450);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 20;
        stall_pct     = 20;
        send_random_stream(300);
    endtask

    // Hold the sink off for a long window while bytes keep coming, so the
    // result queue fills and the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                holding <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                holding <= 1'b0;
            end
        join_none
        send_random_stream(200);
    endtask

    // Stop offering, wait for every pending record, then let the pipe settle.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        stall_pct = 0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n                 = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = '0;
        byte_ch.end_of_packet = 1'b0;
        byte_ch.packet_kind   = KIND_RR;
        rec_ch.ready          = 1'b0;
        holding               = 1'b0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        error_count           = 0;
        bytes_sent            = 0;
        pkt_offset            = 0;
        blocks_left           = '0;
        cur_kind              = KIND_RR;
        mid_packet            = 1'b0;
        scan_phase            = SCAN_HEADER;
        buf_fill              = 0;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop if the run hangs on a handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
